// ----- rtl/core/igcd_pkg.sv -----
// Shared types, constants and helper functions of the image gradient block.
`default_nettype none

package igcd_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 4096;
    localparam int MIN_DIM         = 2;
    localparam int RESET_WIDTH     = 1024;
    localparam int RESET_HEIGHT    = 1024;
    localparam int PIXEL_BITS      = 8;
    localparam int GRAD_BITS       = 10;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int ROW_BITS        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_IDX_BITS    = 1;
    localparam int RES_MAX         = 3;
    localparam int RES_IDX_BITS    = $clog2(RES_MAX);
    localparam int IN_TDATA_BITS   = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS  = 2 * GRAD_BITS + ROW_BITS + COL_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS    = OUT_TDATA_BITS - OUT_FIELD_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

    typedef logic [PIXEL_BITS-1:0]   t_pix;
    typedef logic [GRAD_BITS-1:0]    t_grad;
    typedef logic [COL_BITS-1:0]     t_col;
    typedef logic [ROW_BITS-1:0]     t_row;
    typedef logic [RES_IDX_BITS-1:0] t_res_idx;

    // one line store word: pixel of the row above and of the row above that
    typedef struct packed {
        t_pix up;
        t_pix up2;
    } t_entry;

    typedef struct packed {
        t_pix a;   // above
        t_pix an;  // above, next column
        t_pix am;  // above, previous column
        t_pix b;   // two rows above
    } t_window;

    typedef struct packed {
        logic wr;
        logic row_end;
        t_col wr_col;
        t_col rd_col;
    } t_line_ctrl;

    typedef struct packed {
        t_pix    pix;
        t_window win;
        t_pix    d0;
        t_pix    d1;
        t_row    row;
        t_col    col;
        logic    row0;
        logic    row1;
        logic    last_row;
        logic    first_col;
        logic    last_col;
    } t_calc_in;

    typedef struct packed {
        t_grad gx;
        t_grad gy;
        t_row  row;
        t_col  col;
        logic  last;
        logic  eof;
    } t_result;

    typedef struct packed {
        t_result [RES_MAX-1:0] slot;
        t_res_idx              last_idx;
    } t_result_set;

    function automatic t_grad f_diff(input t_pix x, input t_pix y);
        logic [PIXEL_BITS+1:0] d;
        d = {2'b00, x} - {2'b00, y};
        return GRAD_BITS'(d);
    endfunction

    function automatic t_grad f_diff2(input t_pix x, input t_pix y);
        logic [PIXEL_BITS+1:0] d;
        d = {2'b00, x} - {2'b00, y};
        return GRAD_BITS'({d, 1'b0});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/igcd_line.sv -----
// Line store of the two previous rows with a three-column window on the row above.
`default_nettype none

module igcd_line (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  igcd_pkg::t_line_ctrl i_ctrl,
    input  igcd_pkg::t_pix       i_pix,
    output igcd_pkg::t_window    o_win
);
    import igcd_pkg::*;

    t_entry r_mem [MAX_WIDTH];
    t_entry r_rd;
    t_entry r_cur;
    t_entry r_alt;
    t_entry r_head0;
    t_entry r_head1;
    t_pix   r_am;
    logic   r_use_alt;
    t_entry nxt;
    t_entry wr_entry;
    t_col   rd_addr;

    assign wr_entry = '{up: i_pix, up2: r_cur.up};
    // read data always holds the word one column ahead of the next pixel
    assign rd_addr  = i_ctrl.rd_col + t_col'(1);
    assign nxt      = r_use_alt ? r_alt : r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_mem[i_ctrl.wr_col] <= wr_entry;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_alt <= 1'b0;
        end else if (i_ctrl.wr) begin
            r_use_alt <= i_ctrl.row_end;
        end
    end

    // start of row: first two words come from registers, not the store
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_am <= r_cur.up;
            if (i_ctrl.row_end) begin
                r_cur <= r_head0;
                r_alt <= (i_ctrl.wr_col == t_col'(1)) ? wr_entry : r_head1;
            end else begin
                r_cur <= nxt;
            end
            if (i_ctrl.wr_col == '0) begin
                r_head0 <= wr_entry;
            end
            if (i_ctrl.wr_col == t_col'(1)) begin
                r_head1 <= wr_entry;
            end
        end
    end

    assign o_win = '{a: r_cur.up, an: nxt.up, am: r_am, b: r_cur.up2};

endmodule

`default_nettype wire

// ----- rtl/core/igcd_calc.sv -----
// Gradient arithmetic: builds the up to three results caused by one pixel.
`default_nettype none

module igcd_calc (
    input  igcd_pkg::t_calc_in    i_cin,
    output igcd_pkg::t_result_set o_set,
    output logic                  o_has
);
    import igcd_pkg::*;

    t_result r0;
    t_result r1;
    t_result r2;
    logic    tail;

    assign tail = i_cin.last_row && !i_cin.first_col;

    always_comb begin
        // pixel above
        if (i_cin.first_col) begin
            r0.gx = f_diff2(i_cin.win.an, i_cin.win.a);
        end else if (i_cin.last_col) begin
            r0.gx = f_diff2(i_cin.win.a, i_cin.win.am);
        end else begin
            r0.gx = f_diff(i_cin.win.an, i_cin.win.am);
        end
        r0.gy   = i_cin.row1 ? f_diff2(i_cin.pix, i_cin.win.a)
                             : f_diff(i_cin.pix, i_cin.win.b);
        r0.row  = i_cin.row - t_row'(1);
        r0.col  = i_cin.col;
        r0.last = !tail;
        r0.eof  = 1'b0;

        // last row: pixel to the left
        r1.gx   = (i_cin.col == t_col'(1)) ? f_diff2(i_cin.pix, i_cin.d0)
                                           : f_diff(i_cin.pix, i_cin.d1);
        r1.gy   = f_diff2(i_cin.d0, i_cin.win.am);
        r1.row  = i_cin.row;
        r1.col  = i_cin.col - t_col'(1);
        r1.last = !i_cin.last_col;
        r1.eof  = 1'b0;

        // frame's last pixel
        r2.gx   = f_diff2(i_cin.pix, i_cin.d0);
        r2.gy   = f_diff2(i_cin.pix, i_cin.win.a);
        r2.row  = i_cin.row;
        r2.col  = i_cin.col;
        r2.last = 1'b1;
        r2.eof  = 1'b1;

        o_set.slot = {r2, r1, r0};
        if (tail) begin
            o_set.last_idx = i_cin.last_col ? t_res_idx'(2) : t_res_idx'(1);
        end else begin
            o_set.last_idx = '0;
        end
    end

    assign o_has = !i_cin.row0;

endmodule

`default_nettype wire

// ----- rtl/core/igcd_obuf.sv -----
// Result register: holds the results of one pixel and sends them out one per item.
`default_nettype none

module igcd_obuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  igcd_pkg::t_result_set i_set,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output igcd_pkg::t_result     o_res
);
    import igcd_pkg::*;

    logic        r_vld;
    t_res_idx    r_idx;
    t_result_set r_set;
    logic        at_last;

    assign at_last = (r_idx == r_set.last_idx);
    assign o_free  = !r_vld || (i_ready && at_last);
    assign o_valid = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (r_vld && i_ready) begin
            if (at_last) begin
                r_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + t_res_idx'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_set <= i_set;
        end
    end

    always_comb begin
        unique case (r_idx)
            t_res_idx'(1): o_res = r_set.slot[1];
            t_res_idx'(2): o_res = r_set.slot[2];
            default:       o_res = r_set.slot[0];
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/image_gradient_central_diff_top.sv -----
// Top level of the streaming central-difference image gradient block.
// A result passes through the input register and the result register after its pixel is accepted.
// Throughput: one pixel per cycle on all rows but the last while the output port takes every
// result; on the last row each pixel after the first gives two results and the frame's last pixel
// three, which the single output port sends one at a time. Results lag by one row.
// Reset (sync, active low): counters and handshakes cleared, width and height
// back to 1024; line stores keep their contents. A register write restarts the frame.
`default_nettype none

module image_gradient_central_diff_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [igcd_pkg::IN_TDATA_BITS-1:0]   i_s_axis_tdata,  // pixel
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [igcd_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata,  // grad_x, grad_y, out_row, out_col
    output logic                                 o_m_axis_tlast,  // last_of_run
    output logic                                 o_m_axis_tuser,  // end_of_frame
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [igcd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [igcd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import igcd_pkg::*;

    logic                       cfg_wr;
    logic                       in_acc;
    logic [WIDTH_REG_BITS-1:0]  w_val;
    logic [HEIGHT_REG_BITS-1:0] h_val;
    t_col                       r_last_col;
    t_col                       n_last_col;
    t_row                       r_last_row;
    t_row                       n_last_row;
    t_col                       r_col;
    t_col                       n_col;
    t_row                       r_row;
    t_row                       n_row;
    logic                       at_last_col;
    logic                       at_last_row;
    t_pix                       pix;
    t_pix                       r_d0;
    t_pix                       r_d1;
    t_window                    win;
    t_line_ctrl                 line_ctrl;
    logic                       r_s1_vld;
    t_calc_in                   r_s1;
    t_calc_in                   n_s1;
    t_result_set                calc_set;
    logic                       calc_has;
    logic                       ob_free;
    logic                       ob_load;
    logic                       s1_adv;
    t_result                    ob_res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign w_val       = i_cfg_data[WIDTH_REG_BITS-1:0];
    assign h_val       = i_cfg_data[HEIGHT_REG_BITS-1:0];

    always_comb begin
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH: begin
                    priority if (w_val < WIDTH_REG_BITS'(MIN_DIM)) begin
                        n_last_col = t_col'(MIN_DIM - 1);
                    end else if (w_val > WIDTH_REG_BITS'(MAX_WIDTH)) begin
                        n_last_col = t_col'(MAX_WIDTH - 1);
                    end else begin
                        n_last_col = t_col'(w_val - WIDTH_REG_BITS'(1));
                    end
                end
                CFG_IDX_HEIGHT: begin
                    priority if (h_val < HEIGHT_REG_BITS'(MIN_DIM)) begin
                        n_last_row = t_row'(MIN_DIM - 1);
                    end else if (h_val > HEIGHT_REG_BITS'(MAX_HEIGHT)) begin
                        n_last_row = t_row'(MAX_HEIGHT - 1);
                    end else begin
                        n_last_row = t_row'(h_val - HEIGHT_REG_BITS'(1));
                    end
                end
            endcase
        end
    end

    // frame position
    assign in_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign pix         = i_s_axis_tdata[PIXEL_BITS-1:0];
    assign at_last_col = (r_col == r_last_col);
    assign at_last_row = (r_row == r_last_row);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (at_last_col) begin
                n_col = '0;
                n_row = at_last_row ? '0 : r_row + t_row'(1);
            end else begin
                n_col = r_col + t_col'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= t_col'(RESET_WIDTH - 1);
            r_last_row <= t_row'(RESET_HEIGHT - 1);
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_d1 <= r_d0;
            r_d0 <= pix;
        end
    end

    assign line_ctrl = '{wr: in_acc, row_end: at_last_col, wr_col: r_col, rd_col: n_col};

    igcd_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (line_ctrl),
        .i_pix   (pix),
        .o_win   (win)
    );

    // input register
    always_comb begin
        n_s1.pix       = pix;
        n_s1.win       = win;
        n_s1.d0        = r_d0;
        n_s1.d1        = r_d1;
        n_s1.row       = r_row;
        n_s1.col       = r_col;
        n_s1.row0      = (r_row == '0);
        n_s1.row1      = (r_row == t_row'(1));
        n_s1.last_row  = at_last_row;
        n_s1.first_col = (r_col == '0);
        n_s1.last_col  = at_last_col;
    end

    assign s1_adv          = r_s1_vld && (!calc_has || ob_free);
    assign ob_load         = r_s1_vld && calc_has && ob_free;
    assign o_s_axis_tready = !r_s1_vld || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    igcd_calc u_calc (
        .i_cin (r_s1),
        .o_set (calc_set),
        .o_has (calc_has)
    );

    igcd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ob_load),
        .i_set   (calc_set),
        .o_free  (ob_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (ob_res)
    );

    assign o_m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, ob_res.col, ob_res.row, ob_res.gy, ob_res.gx};
    assign o_m_axis_tlast = ob_res.last;
    assign o_m_axis_tuser = ob_res.eof;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_last_col)
        else $error("column counter beyond row width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_last_row)
        else $error("row counter beyond frame height");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && at_last_col) |=> (r_col == '0))
        else $error("column counter did not wrap at row end");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("frame end item not marked last");

endmodule

`default_nettype wire
